// ----- hw/rtl/md5_pkg.sv -----
package md5_pkg;

  // One input transaction: a message byte, its valid flag and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } md5_in_t;

  // One output transaction: the four final chaining words.
  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  // Operations on the block word store.
  typedef enum logic [1:0] {
    BUF_NONE,
    BUF_BYTE,
    BUF_PAD,
    BUF_ZERO
  } buf_op_e;

  // Request from the sequencer to the block word store.
  typedef struct packed {
    buf_op_e     op;
    logic [5:0]  slot;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } buf_req_t;

  localparam int unsigned Rounds = 64;

  // Slot from which padding no longer leaves room for the length words.
  localparam logic [5:0] LenSlot = 6'd56;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] ChainInit [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] RoundConst [Rounds] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotate amount of a round, chosen by phase and round mod 4.
  function automatic logic [4:0] rot_amt(logic [5:0] rnd);
    logic [3:0] sel;
    logic [4:0] amt;
    sel = {rnd[5:4], rnd[1:0]};
    unique case (sel)
      4'd0:    amt = 5'd7;
      4'd1:    amt = 5'd12;
      4'd2:    amt = 5'd17;
      4'd3:    amt = 5'd22;
      4'd4:    amt = 5'd5;
      4'd5:    amt = 5'd9;
      4'd6:    amt = 5'd14;
      4'd7:    amt = 5'd20;
      4'd8:    amt = 5'd4;
      4'd9:    amt = 5'd11;
      4'd10:   amt = 5'd16;
      4'd11:   amt = 5'd23;
      4'd12:   amt = 5'd6;
      4'd13:   amt = 5'd10;
      4'd14:   amt = 5'd15;
      default: amt = 5'd21;
    endcase
    return amt;
  endfunction

  // Index of the block word that a round consumes.
  function automatic logic [3:0] msg_index(logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] idx;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    idx = r;
      2'd1:    idx = 4'(r * 4'd5 + 4'd1);
      2'd2:    idx = 4'(r * 4'd3 + 4'd5);
      default: idx = 4'(r * 4'd7);
    endcase
    return idx;
  endfunction

endpackage

// ----- hw/rtl/md5_message_digest.sv -----
// MD5 hashing engine taking one message byte per input transaction. The
// transaction that fills a 64-byte block then holds the input off through a
// set-up state, 64 rounds through a single shared round unit and a state that
// adds into the chaining words, so no further byte is taken until that block
// is compressed. A transaction with end_of_message set pads the block and
// compresses it; when fewer than nine byte slots remain a second, zeroed
// block with the length follows before the digest is offered.
// When the closing byte itself fills the block, that block is compressed
// first and a whole padding block follows.
// The digest sits in an output register; the next message may start while
// it waits, and a further digest is held back until it has been taken.
module md5_message_digest (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5_pkg::md5_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output md5_pkg::md5_out_t out_data_o
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_ZERO,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_ZERO,
    AFT_OUT
  } after_e;

  state_e      state_q;
  after_e      after_q;
  logic [5:0]  slot_q;
  logic [63:0] len_q;
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] pre_q;
  logic [5:0]  rnd_q;
  logic        out_valid_q;
  md5_out_t    out_q;

  logic        in_acc;
  buf_req_t    buf_req;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [5:0]  rnd_next;
  logic [31:0] new_b;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rnd_next    = rnd_q + 6'd1;

  // Requests to the block store.
  always_comb begin
    buf_req.op      = BUF_NONE;
    buf_req.slot    = slot_q;
    buf_req.data    = in_data_i.data_byte;
    buf_req.bit_len = len_q;
    if (in_acc && in_data_i.byte_valid) begin
      buf_req.op = BUF_BYTE;
    end else if (state_q == ST_PAD) begin
      buf_req.op = BUF_PAD;
    end else if (state_q == ST_ZERO) begin
      buf_req.op = BUF_ZERO;
    end
  end

  // Word for the round after the current one; outside the rounds, the word of the first round.
  assign rd_addr = (state_q == ST_ROUND) ? msg_index(rnd_next) : msg_index(6'd0);

  md5_block_buf u_buf (
    .clk_i     (clk_i),
    .req_i     (buf_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5_round u_round (
    .rnd_i (rnd_q),
    .b_i   (b_q),
    .c_i   (c_q),
    .d_i   (d_q),
    .pre_i (pre_q),
    .b_o   (new_b)
  );

  // Sequencer, working words and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= AFT_IDLE;
      slot_q      <= '0;
      len_q       <= '0;
      chain_q     <= ChainInit;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      d_q         <= '0;
      pre_q       <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.byte_valid) begin
              slot_q <= slot_q + 6'd1;
              len_q  <= len_q + 64'd8;
              if (slot_q == 6'd63) begin
                state_q <= ST_SETUP;
                after_q <= in_data_i.end_of_message ? AFT_PAD : AFT_IDLE;
              end else if (in_data_i.end_of_message) begin
                state_q <= ST_PAD;
              end
            end else if (in_data_i.end_of_message) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_SETUP: begin
          a_q     <= chain_q[0];
          b_q     <= chain_q[1];
          c_q     <= chain_q[2];
          d_q     <= chain_q[3];
          pre_q   <= chain_q[0] + RoundConst[0] + rd_data;
          rnd_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          a_q   <= d_q;
          b_q   <= new_b;
          c_q   <= b_q;
          d_q   <= c_q;
          pre_q <= d_q + RoundConst[rnd_next] + rd_data;
          rnd_q <= rnd_next;
          if (rnd_q == 6'd63) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          unique case (after_q)
            AFT_IDLE: state_q <= ST_IDLE;
            AFT_PAD:  state_q <= ST_PAD;
            AFT_ZERO: state_q <= ST_ZERO;
            default:  state_q <= ST_EMIT;
          endcase
        end
        ST_PAD: begin
          state_q <= ST_SETUP;
          after_q <= (slot_q >= LenSlot) ? AFT_ZERO : AFT_OUT;
        end
        ST_ZERO: begin
          state_q <= ST_SETUP;
          after_q <= AFT_OUT;
        end
        ST_EMIT: begin
          // Wait for the previous digest to be taken before overwriting it.
          if (!out_valid_q || out_ready_i) begin
            out_q.digest_a <= chain_q[0];
            out_q.digest_b <= chain_q[1];
            out_q.digest_c <= chain_q[2];
            out_q.digest_d <= chain_q[3];
            out_valid_q    <= 1'b1;
            chain_q        <= ChainInit;
            len_q          <= '0;
            slot_q         <= '0;
            rnd_q          <= '0;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/md5_block_buf.sv -----
module md5_block_buf (
  input  logic              clk_i,
  input  md5_pkg::buf_req_t req_i,
  input  logic [3:0]        rd_addr_i,
  output logic [31:0]       rd_data_o
);
  import md5_pkg::*;

  logic [31:0] words_q [16];

  // Byte writes, in-place padding and the zero block with the length words.
  always_ff @(posedge clk_i) begin
    unique case (req_i.op)
      BUF_BYTE: begin
        words_q[req_i.slot[5:2]][{req_i.slot[1:0], 3'b000} +: 8] <= req_i.data;
      end
      BUF_PAD: begin
        for (int w = 0; w < 16; w++) begin
          for (int j = 0; j < 4; j++) begin
            if (6'(w * 4 + j) == req_i.slot) begin
              words_q[w][j*8 +: 8] <= PadByte;
            end else if (6'(w * 4 + j) > req_i.slot) begin
              words_q[w][j*8 +: 8] <= 8'h00;
            end
          end
        end
        if (req_i.slot < LenSlot) begin
          words_q[14] <= req_i.bit_len[31:0];
          words_q[15] <= req_i.bit_len[63:32];
        end
      end
      BUF_ZERO: begin
        for (int w = 0; w < 14; w++) begin
          words_q[w] <= '0;
        end
        words_q[14] <= req_i.bit_len[31:0];
        words_q[15] <= req_i.bit_len[63:32];
      end
      BUF_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Single read port for the word that the next round consumes.
  assign rd_data_o = words_q[rd_addr_i];

endmodule

// ----- hw/rtl/md5_round.sv -----
module md5_round (
  input  logic [5:0]  rnd_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] pre_i,
  output logic [31:0] b_o
);
  import md5_pkg::*;

  logic [31:0] mix;
  logic [31:0] sum;
  logic [63:0] dbl;

  // Boolean function of the current phase.
  always_comb begin
    unique case (rnd_i[5:4])
      2'd0:    mix = (b_i & c_i) | (~b_i & d_i);
      2'd1:    mix = (d_i & b_i) | (~d_i & c_i);
      2'd2:    mix = b_i ^ c_i ^ d_i;
      default: mix = c_i ^ (b_i | ~d_i);
    endcase
  end

  // The precomputed a + K + M joins the mix, then rotate and add b.
  assign sum = mix + pre_i;
  assign dbl = {sum, sum} << rot_amt(rnd_i);
  assign b_o = b_i + dbl[63:32];

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  localparam int unsigned TargetItems   = 1100;
  localparam int unsigned TargetDigests = 40;
  // Allow a good margin after the last digest for the longest close.
  localparam int unsigned SettleCycles  = 300;
  localparam int unsigned CycleLimit    = 400000;

  // Additive constants of the 64 rounds.
  localparam logic [31:0] SineTable [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotation per phase, repeating every four rounds.
  localparam int unsigned ShiftTable [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Message lengths in bytes that land on the padding boundaries.
  localparam int unsigned EdgeLengths [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  localparam md5_out_t NoDigest    = '0;
  localparam md5_out_t EmptyDigest = {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};

  typedef struct packed {
    md5_in_t  item;
    logic     fixed;
    md5_out_t digest;
  } step_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  md5_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  md5_out_t out_data;

  // Predictor state.
  logic [31:0] msg_block [16];
  logic [31:0] chain [4];
  logic [63:0] msg_bits;
  logic [5:0]  fill_slot;

  md5_out_t    digests_due [$];
  int unsigned items_sent = 0;
  int unsigned messages_closed = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Opening directed transactions: idle, empty messages, extreme bytes, a short text,
  // and closes with and without a byte.
  step_row_t opening_steps [13] = '{
    {8'hff, 1'b0, 1'b0, 1'b0, NoDigest},
    {8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    {8'h5a, 1'b0, 1'b1, 1'b1, EmptyDigest},
    {8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
    {8'hff, 1'b1, 1'b1, 1'b0, NoDigest},
    {8'h00, 1'b0, 1'b0, 1'b0, NoDigest},
    {8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    {8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    {8'h63, 1'b1, 1'b1, 1'b0, NoDigest},
    {8'hff, 1'b1, 1'b0, 1'b0, NoDigest},
    {8'haa, 1'b0, 1'b0, 1'b0, NoDigest},
    {8'h55, 1'b0, 1'b1, 1'b0, NoDigest},
    {8'h80, 1'b1, 1'b1, 1'b0, NoDigest}
  };

  md5_message_digest dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Give up if the run hangs.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("md5_message_digest test failed");
    $finish;
  end

  // Start a fresh message in the predictor.
  function automatic void reset_predictor();
    chain[0]  = 32'h67452301;
    chain[1]  = 32'hefcdab89;
    chain[2]  = 32'h98badcfe;
    chain[3]  = 32'h10325476;
    msg_bits  = '0;
    fill_slot = '0;
  endfunction

  // Bytes go into the words little-endian; the first byte of a word clears the rest.
  function automatic void put_byte(int unsigned slot, logic [7:0] value);
    if (slot % 4 == 0) begin
      msg_block[slot / 4] = {24'h0, value};
    end else begin
      msg_block[slot / 4][(slot % 4) * 8 +: 8] = value;
    end
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Run the 64 rounds over the current block and fold the result into the chain.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, mix, sum;
    int unsigned g, phase;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int unsigned i = 0; i < 64; i++) begin
      phase = i / 16;
      case (phase)
        0: begin
          mix = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          mix = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          mix = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          mix = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      mix = mix + a + SineTable[i] + msg_block[g];
      sum = b + rotl(mix, ShiftTable[phase * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = sum;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  // Take one input transaction; returns 1 with the digest when it closes a message.
  function automatic bit absorb_transaction(input md5_in_t item, output md5_out_t digest);
    digest = '0;
    if (item.byte_valid) begin
      put_byte(fill_slot, item.data_byte);
      msg_bits += 64'd8;
      fill_slot += 6'd1;
      if (fill_slot == 6'd0) begin
        compress_block();
      end
    end
    if (!item.end_of_message) begin
      return 1'b0;
    end
    // Padding marker, then zeros to the end of the block.
    put_byte(fill_slot, 8'h80);
    for (int unsigned s = fill_slot + 1; s < 64; s++) begin
      put_byte(s, 8'h00);
    end
    // No room left for the length: flush this block and pad a second one.
    if (fill_slot >= 6'd56) begin
      compress_block();
      foreach (msg_block[w]) begin
        msg_block[w] = '0;
      end
    end
    msg_block[14] = msg_bits[31:0];
    msg_block[15] = msg_bits[63:32];
    compress_block();
    digest.digest_a = chain[0];
    digest.digest_b = chain[1];
    digest.digest_c = chain[2];
    digest.digest_d = chain[3];
    reset_predictor();
    return 1'b1;
  endfunction

  // Offer one transaction after an idle gap, wait for it to be taken, then predict.
  task automatic send_item(input md5_in_t item, input int unsigned gap,
                           input bit fixed = 1'b0, input md5_out_t fixed_digest = '0);
    md5_out_t digest;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.byte_valid || item.end_of_message) begin
      items_sent++;
    end
    if (absorb_transaction(item, digest)) begin
      digests_due.push_back(fixed ? fixed_digest : digest);
      messages_closed++;
    end
  endtask

  // Stop offering input until every outstanding digest has been delivered.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (digests_due.size() != 0);
  endtask

  // Digest receiver with random back-pressure and calm stretches.
  initial begin
    md5_out_t want;
    int unsigned stall;
    bit calm;
    calm = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        calm = !calm;
      end
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (digests_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("digest with none outstanding: %h %h %h %h", out_data.digest_a,
                   out_data.digest_b, out_data.digest_c, out_data.digest_d);
        end
      end else begin
        want = digests_due.pop_front();
        if (out_data.digest_a !== want.digest_a || out_data.digest_b !== want.digest_b ||
            out_data.digest_c !== want.digest_c || out_data.digest_d !== want.digest_d) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("digest mismatch: expected %h %h %h %h, got %h %h %h %h",
                     want.digest_a, want.digest_b, want.digest_c, want.digest_d,
                     out_data.digest_a, out_data.digest_b, out_data.digest_c,
                     out_data.digest_d);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random messages.
  initial begin
    md5_in_t item;
    int unsigned len;
    bit burst;
    bit close_on_byte;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_steps[i]) begin
      send_item(opening_steps[i].item, $urandom_range(0, 10), opening_steps[i].fixed,
                opening_steps[i].digest);
    end
    hold_until_drained();

    // Mostly short messages, a fair share on the block boundaries, some medium ones.
    while (items_sent < TargetItems || messages_closed < TargetDigests) begin
      case ($urandom_range(0, 9))
        0, 1:    len = EdgeLengths[$urandom_range(0, 8)];
        2:       len = $urandom_range(13, 140);
        default: len = $urandom_range(0, 12);
      endcase
      burst = ($urandom_range(0, 3) == 0);
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned n = 0; n < len; n++) begin
        // Occasional idle transaction with random data in the middle of a message.
        if ($urandom_range(0, 9) == 0) begin
          item = {8'($urandom), 1'b0, 1'b0};
          send_item(item, burst ? 0 : $urandom_range(0, 10));
        end
        item = {8'($urandom), 1'b1, 1'(close_on_byte && n == len - 1)};
        send_item(item, burst ? 0 : $urandom_range(0, 10));
      end
      if (!close_on_byte) begin
        item = {8'($urandom), 1'b0, 1'b1};
        send_item(item, burst ? 0 : $urandom_range(0, 10));
      end
      if ($urandom_range(0, 11) == 0) begin
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("md5_message_digest test passed");
    end else begin
      $display("md5_message_digest test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/md5_pkg.sv
hw/rtl/md5_block_buf.sv
hw/rtl/md5_round.sv
hw/rtl/md5_message_digest.sv
bench/tb.sv
